FILE: design/vwt_pkg.sv
// Shared types, constants and the clamp helper function for the vertex-to-window transform.
package vwt_pkg;

  // Default number of fraction bits of the fixed-point format.
  localparam int FRAC_BITS_DEF = 16;

  // Width used for sums that are later clamped to 32 bits.
  localparam int SAT_W = 66;

  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(VAL_MAX);
  localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(VAL_MIN);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd3;
  localparam int CFG_DATA_W = 15;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_XFORM = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_WZERO = 2'd1,
    ST_SAT   = 2'd2
  } status_e;

  typedef struct packed {
    func_e              func;
    logic [4:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] obj_x;
    logic signed [31:0] obj_y;
    logic signed [31:0] obj_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] win_x;
    logic signed [31:0] win_y;
    logic signed [31:0] dev_z;
    status_e            status;
  } out_item_t;

  // Control that travels with an item through the two matrix products.
  typedef struct packed {
    logic               valid;
    logic               xform;
    logic               sat;
    logic [4:0]         idx;
    logic signed [31:0] value;
  } mv_ctl_t;

  // Control that travels with a transform after the products.
  typedef struct packed {
    logic valid;
    logic sat;
  } st_ctl_t;

  typedef struct packed {
    logic valid;
    logic sat;
    logic wzero;
  } dev_ctl_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               sat;
  } sat_t;

  typedef logic signed [31:0] vec4_t [4];
  typedef logic signed [31:0] dev3_t [3];

  // Clamp a wide signed value to 32 bits and flag the clamp.
  function automatic sat_t sat32(input logic signed [SAT_W-1:0] v);
    sat_t r;
    if (v > SAT_HI) begin
      r.val = VAL_MAX;
      r.sat = 1'b1;
    end else if (v < SAT_LO) begin
      r.val = VAL_MIN;
      r.sat = 1'b1;
    end else begin
      r.val = v[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: design/vertex_to_window_transform_top.sv
// Top level of the pipelined vertex-to-window transform.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): an item either loads one
// matrix coefficient (func load; index 0-15 modelview, 16-31 projection, both
// column-major) or transforms one vertex. Loads give no result; each transform
// gives one item on the output channel (out_valid_o / out_stall_i / out_data_o)
// with window x and y, device depth and a status code.
// The configuration port (cfg_we_i, cfg_index_i, cfg_data_i) sets the viewport
// origin and size; write it only while the block is idle.
// From acceptance to a valid result an item passes two stages per matrix product,
// a divider that retires two quotient bits per stage plus an entry and an exit
// stage, two viewport stages and the output register. One item is accepted every
// cycle while the input is not stalled.
// Reset clears both coefficient matrices, sets the viewport to origin 0, size
// 640 by 480, and empties the pipeline. When the receiver stalls, the result is
// held in the output register; the pipeline keeps advancing and accepting items
// while it has an empty slot in front of that register, and stalls otherwise.
module vertex_to_window_transform_top #(
  parameter int FRAC_BITS = vwt_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  vwt_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output vwt_pkg::out_item_t                out_data_o,
  input  logic                              cfg_we_i,
  input  logic [vwt_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [vwt_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  logic signed [14:0] origin_x_q, origin_y_q;
  logic [13:0]        width_q, height_q;

  logic               pipe_en;
  logic               out_ld;
  logic               out_valid_q;
  vwt_pkg::out_item_t out_q;

  vwt_pkg::mv_ctl_t   in_ctl, mv_ctl, pj_ctl;
  vwt_pkg::vec4_t     obj_vec, eye_vec, clip_vec;
  logic               mv_we, pj_we;
  vwt_pkg::st_ctl_t   div_ctl_in;
  vwt_pkg::dev_ctl_t  dev_ctl;
  vwt_pkg::dev3_t     dev_vec;
  logic               view_vld;
  vwt_pkg::out_item_t view_item;

  // Viewport registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      width_q    <= 14'd640;
      height_q   <= 14'd480;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        vwt_pkg::CFG_ORIGIN_X: origin_x_q <= cfg_data_i;
        vwt_pkg::CFG_ORIGIN_Y: origin_y_q <= cfg_data_i;
        vwt_pkg::CFG_WIDTH:    width_q    <= cfg_data_i[13:0];
        vwt_pkg::CFG_HEIGHT:   height_q   <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  // Flow control: the whole pipeline moves unless the output is held and the
  // last stage in front of it is occupied.
  assign out_ld     = !out_valid_q || !out_stall_i;
  assign pipe_en    = !view_vld || out_ld;
  assign in_stall_o = !pipe_en;

  // Entry: modelview loads are written at acceptance.
  always_comb begin
    in_ctl.valid = in_valid_i;
    in_ctl.xform = (in_data_i.func == vwt_pkg::FUNC_XFORM);
    in_ctl.sat   = 1'b0;
    in_ctl.idx   = in_data_i.coef_index;
    in_ctl.value = in_data_i.coef_value;
    obj_vec[0]   = in_data_i.obj_x;
    obj_vec[1]   = in_data_i.obj_y;
    obj_vec[2]   = in_data_i.obj_z;
    obj_vec[3]   = 32'sd1 <<< FRAC_BITS;
  end

  assign mv_we = in_valid_i && pipe_en && (in_data_i.func == vwt_pkg::FUNC_LOAD)
                 && !in_data_i.coef_index[4];

  vwt_matvec #(.FRAC_BITS(FRAC_BITS)) u_modelview (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .ctl_i   (in_ctl),
    .vec_i   (obj_vec),
    .we_i    (mv_we),
    .waddr_i (in_data_i.coef_index[3:0]),
    .wdata_i (in_data_i.coef_value),
    .ctl_o   (mv_ctl),
    .vec_o   (eye_vec)
  );

  // Projection loads travel with the items and are written where the
  // projection product reads its coefficients, which keeps item order.
  assign pj_we = pipe_en && mv_ctl.valid && !mv_ctl.xform && mv_ctl.idx[4];

  vwt_matvec #(.FRAC_BITS(FRAC_BITS)) u_projection (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .ctl_i   (mv_ctl),
    .vec_i   (eye_vec),
    .we_i    (pj_we),
    .waddr_i (mv_ctl.idx[3:0]),
    .wdata_i (mv_ctl.value),
    .ctl_o   (pj_ctl),
    .vec_o   (clip_vec)
  );

  // Only transforms continue past the products.
  assign div_ctl_in.valid = pj_ctl.valid && pj_ctl.xform;
  assign div_ctl_in.sat   = pj_ctl.sat;

  vwt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .ctl_i  (div_ctl_in),
    .clip_i (clip_vec),
    .ctl_o  (dev_ctl),
    .dev_o  (dev_vec)
  );

  vwt_view #(.FRAC_BITS(FRAC_BITS)) u_view (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (pipe_en),
    .ctl_i      (dev_ctl),
    .dev_i      (dev_vec),
    .origin_x_i (origin_x_q),
    .origin_y_i (origin_y_q),
    .width_i    (width_q),
    .height_i   (height_q),
    .vld_o      (view_vld),
    .item_o     (view_item)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ld) begin
      out_valid_q <= view_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld && view_vld) begin
      out_q <= view_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A free receiver never backs up the input.
  a_no_stall_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while the output is free");

  // A held result with an occupied last stage must stop the input.
  a_stall_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i && view_vld) |-> in_stall_o)
    else $error("input accepted while the pipeline is blocked");

  // A zero w gives an extreme or zero depth.
  a_wzero_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == vwt_pkg::ST_WZERO) |->
      (out_data_o.dev_z == vwt_pkg::VAL_MAX || out_data_o.dev_z == vwt_pkg::VAL_MIN
       || out_data_o.dev_z == 32'sd0))
    else $error("zero-w result with a finite depth");

endmodule

FILE: design/vwt_matvec.sv
// Two-stage 4x4 matrix times vector product with its own coefficient store.
module vwt_matvec #(
  parameter int FRAC_BITS = vwt_pkg::FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  vwt_pkg::mv_ctl_t ctl_i,
  input  vwt_pkg::vec4_t   vec_i,
  input  logic             we_i,
  input  logic [3:0]       waddr_i,
  input  logic [31:0]      wdata_i,
  output vwt_pkg::mv_ctl_t ctl_o,
  output vwt_pkg::vec4_t   vec_o
);

  logic signed [31:0] coef_q [16];
  logic signed [63:0] prod_q [16];
  vwt_pkg::mv_ctl_t   ctl1_q, ctl2_q;
  vwt_pkg::mv_ctl_t   ctl2_d;
  vwt_pkg::vec4_t     vec_q;
  logic signed [vwt_pkg::SAT_W-1:0] acc [4];
  vwt_pkg::sat_t      row_s [4];
  logic               row_sat;

  // Coefficient store, column-major: row r, column c sits at entry c*4+r.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) coef_q[i] <= '0;
    end else if (we_i) begin
      coef_q[waddr_i] <= wdata_i;
    end
  end

  // Stage one: all sixteen exact products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          prod_q[c*4+r] <= 64'(coef_q[c*4+r]) * 64'(vec_i[c]);
        end
      end
    end
  end

  // Control of stage two picks up the clamp flag of this product.
  always_comb begin
    ctl2_d     = ctl1_q;
    ctl2_d.sat = ctl1_q.sat | row_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else if (en_i) begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl2_d;
    end
  end

  // Stage two: floor-shift each product, sum the row and clamp.
  always_comb begin
    row_sat = 1'b0;
    for (int r = 0; r < 4; r++) begin
      acc[r] = '0;
      for (int c = 0; c < 4; c++) begin
        acc[r] = acc[r] + vwt_pkg::SAT_W'(prod_q[c*4+r] >>> FRAC_BITS);
      end
      row_s[r] = vwt_pkg::sat32(acc[r]);
      row_sat  = row_sat | row_s[r].sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 4; r++) vec_q[r] <= row_s[r].val;
    end
  end

  assign ctl_o = ctl2_q;
  assign vec_o = vec_q;

endmodule

FILE: design/vwt_div.sv
// Pipelined sign-magnitude divider that turns clip coordinates into device coordinates.
module vwt_div #(
  parameter int FRAC_BITS = vwt_pkg::FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  vwt_pkg::st_ctl_t  ctl_i,
  input  vwt_pkg::vec4_t    clip_i,
  output vwt_pkg::dev_ctl_t ctl_o,
  output vwt_pkg::dev3_t    dev_o
);

  localparam int BPS  = 2;
  localparam int NSTG = (32 + FRAC_BITS + BPS - 1) / BPS;
  localparam int DVW  = NSTG * BPS;

  typedef struct packed {
    logic neg;
    logic npos;
    logic nneg;
  } lane_flag_t;

  logic [DVW-1:0]    rq_q   [NSTG+1][3];
  logic [32:0]       rem_q  [NSTG+1][3];
  lane_flag_t        flag_q [NSTG+1][3];
  logic [31:0]       dsr_q  [NSTG+1];
  vwt_pkg::dev_ctl_t ctl_q  [NSTG+1];
  vwt_pkg::dev_ctl_t ctl_out_q;
  vwt_pkg::dev_ctl_t ctl_out_d;
  vwt_pkg::dev3_t    dev_q;
  vwt_pkg::dev3_t    dev_d;
  logic [2:0]        lane_sat;
  logic [31:0]       num_mag [3];
  logic [31:0]       w_mag;

  // Prepare magnitudes, result signs and the zero-w flag.
  always_comb begin
    w_mag = clip_i[3][31] ? (~clip_i[3] + 32'd1) : clip_i[3];
    for (int i = 0; i < 3; i++) begin
      num_mag[i] = clip_i[i][31] ? (~clip_i[i] + 32'd1) : clip_i[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dsr_q[0] <= w_mag;
      for (int i = 0; i < 3; i++) begin
        rq_q[0][i]        <= DVW'({num_mag[i], {FRAC_BITS{1'b0}}});
        rem_q[0][i]       <= '0;
        flag_q[0][i].neg  <= clip_i[i][31] ^ clip_i[3][31];
        flag_q[0][i].npos <= (clip_i[i] > 32'sd0);
        flag_q[0][i].nneg <= clip_i[i][31];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q[0] <= '0;
    end else if (en_i) begin
      ctl_q[0] <= '{valid: ctl_i.valid, sat: ctl_i.sat, wzero: (clip_i[3] == 32'sd0)};
    end
  end

  // Restoring division, BPS quotient bits per stage.
  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    logic [DVW-1:0] rq_d  [3];
    logic [32:0]    rem_d [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rq_d[i]  = rq_q[s][i];
        rem_d[i] = rem_q[s][i];
        for (int b = 0; b < BPS; b++) begin
          rem_d[i] = {rem_d[i][31:0], rq_d[i][DVW-1]};
          rq_d[i]  = {rq_d[i][DVW-2:0], 1'b0};
          if (rem_d[i] >= {1'b0, dsr_q[s]}) begin
            rem_d[i] = rem_d[i] - {1'b0, dsr_q[s]};
            rq_d[i][0] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dsr_q[s+1] <= dsr_q[s];
        for (int i = 0; i < 3; i++) begin
          rq_q[s+1][i]   <= rq_d[i];
          rem_q[s+1][i]  <= rem_d[i];
          flag_q[s+1][i] <= flag_q[s][i];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[s+1] <= '0;
      end else if (en_i) begin
        ctl_q[s+1] <= ctl_q[s];
      end
    end
  end

  // Apply sign, clamp, and handle a zero w.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lane_sat[i] = 1'b0;
      if (ctl_q[NSTG].wzero) begin
        if (flag_q[NSTG][i].npos) begin
          dev_d[i] = vwt_pkg::VAL_MAX;
        end else if (flag_q[NSTG][i].nneg) begin
          dev_d[i] = vwt_pkg::VAL_MIN;
        end else begin
          dev_d[i] = '0;
        end
      end else if (!flag_q[NSTG][i].neg) begin
        if (rq_q[NSTG][i] > DVW'(32'h7FFF_FFFF)) begin
          dev_d[i]    = vwt_pkg::VAL_MAX;
          lane_sat[i] = 1'b1;
        end else begin
          dev_d[i] = rq_q[NSTG][i][31:0];
        end
      end else begin
        if (rq_q[NSTG][i] > DVW'(32'h8000_0000)) begin
          dev_d[i]    = vwt_pkg::VAL_MIN;
          lane_sat[i] = 1'b1;
        end else begin
          dev_d[i] = 32'd0 - rq_q[NSTG][i][31:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dev_q <= dev_d;
    end
  end

  // Exit control picks up the clamp flags of the three lanes.
  always_comb begin
    ctl_out_d     = ctl_q[NSTG];
    ctl_out_d.sat = ctl_q[NSTG].sat | (|lane_sat);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_out_q <= '0;
    end else if (en_i) begin
      ctl_out_q <= ctl_out_d;
    end
  end

  assign ctl_o = ctl_out_q;
  assign dev_o = dev_q;

endmodule

FILE: design/vwt_view.sv
// Two-stage viewport mapping of device x and y to window coordinates.
module vwt_view #(
  parameter int FRAC_BITS = vwt_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  vwt_pkg::dev_ctl_t  ctl_i,
  input  vwt_pkg::dev3_t     dev_i,
  input  logic signed [14:0] origin_x_i,
  input  logic signed [14:0] origin_y_i,
  input  logic [13:0]        width_i,
  input  logic [13:0]        height_i,
  output logic               vld_o,
  output vwt_pkg::out_item_t item_o
);

  localparam logic signed [32:0] ONE = 33'sd1 <<< FRAC_BITS;

  logic signed [32:0] dpo_x, dpo_y;
  logic signed [47:0] prod_x_q, prod_y_q;
  logic signed [31:0] dz_q;
  vwt_pkg::dev_ctl_t  ctl1_q;
  vwt_pkg::sat_t      sx, sy;
  logic               any_sat;
  vwt_pkg::out_item_t item_d, item_q;
  logic               vld_q;

  // Stage one: (d + one) * size.
  assign dpo_x = 33'(dev_i[0]) + ONE;
  assign dpo_y = 33'(dev_i[1]) + ONE;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_x_q <= dpo_x * $signed({1'b0, width_i});
      prod_y_q <= dpo_y * $signed({1'b0, height_i});
      dz_q     <= dev_i[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      vld_q  <= 1'b0;
    end else if (en_i) begin
      ctl1_q <= ctl_i;
      vld_q  <= ctl1_q.valid;
    end
  end

  // Stage two: halve toward minus infinity, add the origin, clamp.
  always_comb begin
    sx = vwt_pkg::sat32(vwt_pkg::SAT_W'(prod_x_q >>> 1)
                        + (vwt_pkg::SAT_W'(origin_x_i) <<< FRAC_BITS));
    sy = vwt_pkg::sat32(vwt_pkg::SAT_W'(prod_y_q >>> 1)
                        + (vwt_pkg::SAT_W'(origin_y_i) <<< FRAC_BITS));
    any_sat      = ctl1_q.sat | sx.sat | sy.sat;
    item_d.win_x = sx.val;
    item_d.win_y = sy.val;
    item_d.dev_z = dz_q;
    if (ctl1_q.wzero) begin
      item_d.status = vwt_pkg::ST_WZERO;
    end else if (any_sat) begin
      item_d.status = vwt_pkg::ST_SAT;
    end else begin
      item_d.status = vwt_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

FILE: sim/vertex_to_window_transform_top_tb.sv
// Self-checking testbench for the pipelined vertex-to-window transform.
`timescale 1ns / 100ps

module vertex_to_window_transform_top_tb;

  localparam int FRAC = vwt_pkg::FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) << FRAC;
  localparam int PAUSE_CYCLES = 45;
  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 1530;
  localparam int NUM_PHASES = 6;
  localparam int HOLD_CYCLES = 400;

  typedef longint vec_t [4];

  typedef struct {
    vwt_pkg::in_item_t  item;
    bit                 typed;
    vwt_pkg::out_item_t result;
  } row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  vwt_pkg::in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  vwt_pkg::out_item_t out_data;
  logic      cfg_we;
  logic [vwt_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [vwt_pkg::CFG_DATA_W-1:0] cfg_data;

  // Typed expectation that travels with the item on the input channel.
  logic      row_typed;
  vwt_pkg::out_item_t row_result;

  // Predictor copy of the block state.
  logic signed [31:0] coef_mem [32];
  longint org_x, org_y, vp_w, vp_h;

  vwt_pkg::out_item_t window_q [$];
  int        mismatches = 0;
  int        send_idle_pct;
  int        recv_idle_pct;
  bit        hold_req = 1'b0;
  bit        hold_taken = 1'b0;
  int        hold_cycles = 0;
  int        quiet_cycles = 0;
  row_t      rows [$];

  vertex_to_window_transform_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Clock with a 12 ns period.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Clamp to 32 bits and note the clamp.
  function automatic longint clamp32(longint v, inout bit sat);
    if (v > longint'(vwt_pkg::VAL_MAX)) begin
      sat = 1'b1;
      return longint'(vwt_pkg::VAL_MAX);
    end
    if (v < longint'(vwt_pkg::VAL_MIN)) begin
      sat = 1'b1;
      return longint'(vwt_pkg::VAL_MIN);
    end
    return v;
  endfunction

  // One matrix-vector product over a column-major matrix in the store.
  function automatic void mat_mul(int base, input vec_t vi, output vec_t vo, inout bit sat);
    longint acc;
    for (int r = 0; r < 4; r++) begin
      acc = 0;
      for (int c = 0; c < 4; c++)
        acc += (longint'(coef_mem[base + c * 4 + r]) * vi[c]) >>> FRAC;
      vo[r] = clamp32(acc, sat);
    end
  endfunction

  // Expected window coordinates, depth and status for one vertex.
  function automatic vwt_pkg::out_item_t project_vertex(vwt_pkg::in_item_t it);
    vec_t obj, eye, clip;
    longint dev [3];
    longint wx, wy;
    bit sat;
    bit wzero;
    vwt_pkg::out_item_t r;
    sat = 1'b0;
    obj[0] = longint'(it.obj_x);
    obj[1] = longint'(it.obj_y);
    obj[2] = longint'(it.obj_z);
    obj[3] = ONE;
    mat_mul(0, obj, eye, sat);
    mat_mul(16, eye, clip, sat);
    wzero = (clip[3] == 0);
    for (int i = 0; i < 3; i++) begin
      if (wzero)
        dev[i] = clip[i] > 0 ? longint'(vwt_pkg::VAL_MAX)
               : (clip[i] < 0 ? longint'(vwt_pkg::VAL_MIN) : 0);
      else
        dev[i] = clamp32((clip[i] * ONE) / clip[3], sat);
    end
    wx = clamp32((((dev[0] + ONE) * vp_w) >>> 1) + org_x * ONE, sat);
    wy = clamp32((((dev[1] + ONE) * vp_h) >>> 1) + org_y * ONE, sat);
    r.win_x = wx[31:0];
    r.win_y = wy[31:0];
    r.dev_z = dev[2][31:0];
    r.status = wzero ? vwt_pkg::ST_WZERO : (sat ? vwt_pkg::ST_SAT : vwt_pkg::ST_OK);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
  endtask

  // Input monitor: reset clears the store, loads update it, transforms queue
  // an expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 32; i++) coef_mem[i] = '0;
    end else if (in_valid && !in_stall) begin
      if (in_data.func == vwt_pkg::FUNC_LOAD)
        coef_mem[in_data.coef_index] = in_data.coef_value;
      else if (row_typed)
        window_q.push_back(row_result);
      else
        window_q.push_back(project_vertex(in_data));
    end
  end

  // Output monitor: compare each result with the oldest expectation.
  always @(posedge clk) begin
    vwt_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (window_q.size() == 0) begin
        report_mismatch("unexpected item", out_data.win_x, 32'h0);
      end else begin
        want = window_q.pop_front();
        if (out_data.win_x !== want.win_x) report_mismatch("win_x", out_data.win_x, want.win_x);
        if (out_data.win_y !== want.win_y) report_mismatch("win_y", out_data.win_y, want.win_y);
        if (out_data.dev_z !== want.dev_z) report_mismatch("dev_z", out_data.dev_z, want.dev_z);
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
      end
    end
  end

  // Receiver: random stalls, or a long hold-off once it is requested.
  always @(posedge clk) begin
    if (!rst_n)
      out_stall <= 1'b0;
    else if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_cycles = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else
      out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog expired with %0d results pending", window_q.size());
      $display("** vertex_to_window_transform_top: FAILED **");
      $finish;
    end
  end

  // Drive one item; entered and left just after a rising edge.
  task automatic send_item(vwt_pkg::in_item_t it, bit typed, vwt_pkg::out_item_t res);
    bit acc;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_data    <= it;
    row_typed  <= typed;
    row_result <= res;
    do begin
      @(negedge clk);
      acc = !in_stall;
      @(posedge clk);
    end while (!acc);
  endtask

  // Write one viewport register and mirror it in the predictor.
  task automatic write_cfg(logic [vwt_pkg::CFG_IDX_W-1:0] idx,
                           logic [vwt_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      vwt_pkg::CFG_ORIGIN_X: org_x = longint'($signed(val));
      vwt_pkg::CFG_ORIGIN_Y: org_y = longint'($signed(val));
      vwt_pkg::CFG_WIDTH:    vp_w = longint'(val[13:0]);
      vwt_pkg::CFG_HEIGHT:   vp_h = longint'(val[13:0]);
      default: ;
    endcase
  endtask

  // Wait until every result is back and the pipeline has drained.
  task automatic drain();
    in_valid <= 1'b0;
    while (window_q.size() != 0) @(posedge clk);
    repeat (PAUSE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(4))
      0: return 32'($signed($urandom_range(8 << FRAC)) - (4 << FRAC));
      1: return $urandom;
      2: return 32'($signed($urandom_range(2048 << FRAC)) - (1024 << FRAC));
      3: return ONE[31:0];
      default: begin
        case ($urandom_range(3))
          0: return vwt_pkg::VAL_MAX;
          1: return vwt_pkg::VAL_MIN;
          2: return 32'h0;
          default: return -ONE[31:0];
        endcase
      end
    endcase
  endfunction

  function automatic vwt_pkg::in_item_t rand_item();
    vwt_pkg::in_item_t it;
    it.func       = ($urandom_range(99) < 35) ? vwt_pkg::FUNC_LOAD : vwt_pkg::FUNC_XFORM;
    it.coef_index = 5'($urandom_range(31));
    it.coef_value = rand_word();
    it.obj_x      = rand_word();
    it.obj_y      = rand_word();
    it.obj_z      = rand_word();
    return it;
  endfunction

  task automatic add_row(vwt_pkg::func_e f, int idx, logic [31:0] cv, logic [31:0] x,
                         logic [31:0] y, logic [31:0] z, bit typed,
                         vwt_pkg::out_item_t res);
    row_t r;
    r.item.func       = f;
    r.item.coef_index = 5'(idx);
    r.item.coef_value = cv;
    r.item.obj_x      = x;
    r.item.obj_y      = y;
    r.item.obj_z      = z;
    r.typed  = typed;
    r.result = res;
    rows.push_back(r);
  endtask

  initial begin
    vwt_pkg::out_item_t reset_res;
    vwt_pkg::out_item_t none;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    row_typed = 1'b0;
    row_result = '0;
    cfg_we = 1'b0;
    cfg_index = vwt_pkg::CFG_ORIGIN_X;
    cfg_data = '0;
    send_idle_pct = 23;
    recv_idle_pct = 86;
    org_x = 0;
    org_y = 0;
    vp_w = 640;
    vp_h = 480;
    none = '0;

    // With an all-zero store, clip w is zero and every vertex lands mid-viewport.
    reset_res.win_x  = 32'(320 << FRAC);
    reset_res.win_y  = 32'(240 << FRAC);
    reset_res.dev_z  = '0;
    reset_res.status = vwt_pkg::ST_WZERO;
    add_row(vwt_pkg::FUNC_XFORM, 0, 0, 0, 0, 0, 1, reset_res);
    add_row(vwt_pkg::FUNC_XFORM, 0, 0, vwt_pkg::VAL_MAX, vwt_pkg::VAL_MAX,
            vwt_pkg::VAL_MAX, 1, reset_res);
    add_row(vwt_pkg::FUNC_XFORM, 0, 0, vwt_pkg::VAL_MIN, vwt_pkg::VAL_MIN,
            vwt_pkg::VAL_MIN, 1, reset_res);
    // Identity for both matrices.
    for (int i = 0; i < 4; i++) begin
      add_row(vwt_pkg::FUNC_LOAD, i * 5, ONE[31:0], 0, 0, 0, 0, none);
      add_row(vwt_pkg::FUNC_LOAD, 16 + i * 5, ONE[31:0], 0, 0, 0, 0, none);
    end
    add_row(vwt_pkg::FUNC_XFORM, 0, 0, ONE[31:0], 2 * ONE[31:0], -ONE[31:0], 0, none);
    add_row(vwt_pkg::FUNC_XFORM, 0, 0, vwt_pkg::VAL_MAX, vwt_pkg::VAL_MIN,
            vwt_pkg::VAL_MAX, 0, none);
    add_row(vwt_pkg::FUNC_XFORM, 0, 0, vwt_pkg::VAL_MIN, vwt_pkg::VAL_MAX,
            vwt_pkg::VAL_MIN, 0, none);
    // Extreme coefficients push the sums into saturation.
    add_row(vwt_pkg::FUNC_LOAD, 0, vwt_pkg::VAL_MAX, 0, 0, 0, 0, none);
    add_row(vwt_pkg::FUNC_LOAD, 31, vwt_pkg::VAL_MIN, 0, 0, 0, 0, none);
    add_row(vwt_pkg::FUNC_XFORM, 0, 0, vwt_pkg::VAL_MAX, ONE[31:0], ONE[31:0], 0, none);
    // Projection w row of zero: zero clip w for positive, negative and zero numerators.
    add_row(vwt_pkg::FUNC_LOAD, 31, 0, 0, 0, 0, 0, none);
    add_row(vwt_pkg::FUNC_LOAD, 0, ONE[31:0], 0, 0, 0, 0, none);
    add_row(vwt_pkg::FUNC_XFORM, 0, 0, ONE[31:0], -ONE[31:0], 0, 0, none);
    add_row(vwt_pkg::FUNC_LOAD, 31, ONE[31:0], 0, 0, 0, 0, none);
    add_row(vwt_pkg::FUNC_XFORM, 0, 0, -ONE[31:0], ONE[31:0], ONE[31:0], 0, none);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset viewport.
    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].result);
    drain();

    // Random phases, each under its own viewport; the idling mode changes every two phases.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          write_cfg(vwt_pkg::CFG_ORIGIN_X, 15'h4000);
          write_cfg(vwt_pkg::CFG_ORIGIN_Y, 15'h4000);
          write_cfg(vwt_pkg::CFG_WIDTH, 15'd0);
          write_cfg(vwt_pkg::CFG_HEIGHT, 15'd0);
        end
        1: begin
          write_cfg(vwt_pkg::CFG_ORIGIN_X, 15'h3FFF);
          write_cfg(vwt_pkg::CFG_ORIGIN_Y, 15'h3FFF);
          write_cfg(vwt_pkg::CFG_WIDTH, 15'h3FFF);
          write_cfg(vwt_pkg::CFG_HEIGHT, 15'h3FFF);
        end
        default: begin
          write_cfg(vwt_pkg::CFG_ORIGIN_X, 15'($urandom));
          write_cfg(vwt_pkg::CFG_ORIGIN_Y, 15'($urandom));
          write_cfg(vwt_pkg::CFG_WIDTH, 15'($urandom_range(2048)));
          write_cfg(vwt_pkg::CFG_HEIGHT, 15'($urandom_range(16383)));
        end
      endcase
      send_idle_pct = (p < 2) ? 23 : ((p < 4) ? 86 : 0);
      recv_idle_pct = (p < 2) ? 86 : ((p < 4) ? 23 : 0);
      // Long receiver hold-off while the sender keeps offering items.
      if (p == 4) hold_req = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS / NUM_PHASES; n++) send_item(rand_item(), 0, none);
      drain();
    end

    if (mismatches == 0)
      $display("** vertex_to_window_transform_top: PASSED **");
    else
      $display("** vertex_to_window_transform_top: FAILED **");
    $finish;
  end

endmodule
